// File: hdl/qts_pkg.sv
// ----------------------------------------------------------------------------
// qts_pkg: shared types and constants of the quantum thread scheduler
// Operation codes, field widths and the input and result word layouts.
// ----------------------------------------------------------------------------
package qts_pkg;

    // Default sizing of the slot table
    localparam int THREAD_SLOTS_DEF = 16;
    localparam int QUANTUM_BITS_DEF = 8;

    // Fixed widths of the word fields
    localparam int OP_W          = 2;
    localparam int SLOT_FIELD_W  = 4;
    localparam int PRIO_W        = 6;
    localparam int QUANT_FIELD_W = 8;
    localparam int PROC_W        = 8;

    // Operation codes; code 3 is unused and ignored
    localparam logic [OP_W-1:0] OP_SET   = 2'd0;
    localparam logic [OP_W-1:0] OP_YIELD = 2'd1;
    localparam logic [OP_W-1:0] OP_SCHED = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [SLOT_FIELD_W-1:0]  slot;
        logic [PRIO_W-1:0]        priority_req;
        logic                     running;
        logic [QUANT_FIELD_W-1:0] quantum;
        logic [PROC_W-1:0]        process_id;
    } qts_in_t;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] chosen_slot;
        logic                    chose_idle;
        logic                    context_switch;
        logic                    address_switch;
        logic                    recalculated;
    } qts_out_t;

endpackage

// File: hdl/quantum_thread_scheduler.sv
// ----------------------------------------------------------------------------
// quantum_thread_scheduler: epoch-based goodness scheduler over a slot table
// Set and yield update the table; schedule scans it for the runnable slot
// with the largest remaining quantum and refills all quanta when it is zero.
// ----------------------------------------------------------------------------
// Timing: a set or a yield word is taken and produces no result.
// A schedule word runs one scan pass over the table through a single read
// port, one slot per cycle, into the result register. When the best
// runnable quantum is zero a refill pass follows over the same port.
// The input side is not ready while a schedule is in progress; a finished
// result waits in the output register while the next word is taken. No
// clearing pass is needed after reset: only the runnable flags are
// cleared, and a slot's stored fields are read for a choice only after a
// set has written them.
module quantum_thread_scheduler
    import qts_pkg::*;
#(
    parameter int THREAD_SLOTS = THREAD_SLOTS_DEF,
    parameter int QUANTUM_BITS = QUANTUM_BITS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  qts_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output qts_out_t m_data
);

    localparam int SLOT_W = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int THR_W  = $clog2(THREAD_SLOTS + 1);
    localparam int CNT_W  = $clog2(THREAD_SLOTS + 1);
    localparam int SUM_W  = ((QUANTUM_BITS > PRIO_W) ? QUANTUM_BITS : PRIO_W) + 1;

    localparam logic [THR_W-1:0]        IDLE_THREAD = THR_W'(THREAD_SLOTS);
    localparam logic [CNT_W-1:0]        CNT_END     = CNT_W'(THREAD_SLOTS);
    localparam logic [SUM_W-1:0]        QMAX_SUM    = SUM_W'((1 << QUANTUM_BITS) - 1);
    localparam logic [QUANTUM_BITS-1:0] QMAX        = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REFILL,
        ST_FINISH
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    pipe_vld_reg;
    logic [SLOT_W-1:0]       pipe_idx_reg;
    logic                    found_reg;
    logic [QUANTUM_BITS-1:0] best_q_reg;
    logic [SLOT_W-1:0]       choice_reg;
    logic                    refill_reg;
    logic [THREAD_SLOTS-1:0] runnable_reg;
    logic [THR_W-1:0]        cur_thread_reg;
    logic [PROC_W-1:0]       cur_proc_reg;
    logic                    m_valid_reg;
    qts_out_t                m_data_reg;

    // Slot table storage
    logic [PRIO_W-1:0]       prio_mem  [THREAD_SLOTS];
    logic [QUANTUM_BITS-1:0] quant_mem [THREAD_SLOTS];
    logic [PROC_W-1:0]       proc_mem  [THREAD_SLOTS];
    logic [PRIO_W-1:0]       prio_rd_reg;
    logic [QUANTUM_BITS-1:0] quant_rd_reg;
    logic [PROC_W-1:0]       proc_rd_reg;

    logic                    in_fire;
    logic                    out_free;
    logic                    slot_ok;
    logic [SLOT_W-1:0]       set_addr;
    logic [QUANTUM_BITS-1:0] set_quant;
    logic [SLOT_W-1:0]       scan_addr;
    logic                    cur_is_slot;
    logic                    quant_we;
    logic [SLOT_W-1:0]       quant_waddr;
    logic [QUANTUM_BITS-1:0] quant_wdata;
    logic                    table_we;
    logic [SUM_W-1:0]        refill_sum;
    logic [QUANTUM_BITS-1:0] refill_q;
    logic                    pass_done;
    logic [THR_W-1:0]        choice_full;
    logic [PROC_W-1:0]       choice_proc;
    logic [SLOT_W+SLOT_FIELD_W-1:0]          slot_ext;
    logic [QUANTUM_BITS+QUANT_FIELD_W-1:0]   quant_ext;
    logic [SLOT_W+SLOT_FIELD_W-1:0]          choice_ext;

    // Handshake and field conversions
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign slot_ext  = {{SLOT_W{1'b0}}, s_data.slot};
    assign set_addr  = slot_ext[SLOT_W-1:0];
    assign slot_ok   = (int'(s_data.slot) < THREAD_SLOTS);
    assign quant_ext = {{QUANTUM_BITS{1'b0}}, s_data.quantum};
    assign set_quant = quant_ext[QUANTUM_BITS-1:0];
    assign scan_addr = cnt_reg[SLOT_W-1:0];
    assign cur_is_slot = (cur_thread_reg != IDLE_THREAD);
    assign pass_done = (cnt_reg == CNT_END) && !pipe_vld_reg;

    // Refill value: priority plus a quarter of the old quantum, saturated
    assign refill_sum = SUM_W'(prio_rd_reg) + SUM_W'(quant_rd_reg >> 2);
    assign refill_q   = (refill_sum > QMAX_SUM) ? QMAX : refill_sum[QUANTUM_BITS-1:0];

    // Result fields of the finished scan
    assign choice_full = found_reg ? THR_W'(choice_reg) : IDLE_THREAD;
    assign choice_proc = found_reg ? proc_rd_reg : '0;
    assign choice_ext  = {{SLOT_FIELD_W{1'b0}}, choice_reg};

    // Steer the table write ports
    always_comb begin
        table_we    = in_fire && (s_data.operation == OP_SET) && slot_ok;
        quant_we    = table_we;
        quant_waddr = set_addr;
        quant_wdata = set_quant;
        if (in_fire && (s_data.operation == OP_YIELD) && cur_is_slot) begin
            quant_we    = 1'b1;
            quant_waddr = cur_thread_reg[SLOT_W-1:0];
            quant_wdata = '0;
        end
        if ((state_reg == ST_REFILL) && pipe_vld_reg) begin
            quant_we    = 1'b1;
            quant_waddr = pipe_idx_reg;
            quant_wdata = refill_q;
        end
    end

    // Quantum memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (quant_we) begin
            quant_mem[quant_waddr] <= quant_wdata;
        end
        quant_rd_reg <= quant_mem[scan_addr];
    end

    // Priority memory
    always_ff @(posedge aclk) begin
        if (table_we) begin
            prio_mem[set_addr] <= s_data.priority_req;
        end
        prio_rd_reg <= prio_mem[scan_addr];
    end

    // Process memory, read at the current choice
    always_ff @(posedge aclk) begin
        if (table_we) begin
            proc_mem[set_addr] <= s_data.process_id;
        end
        proc_rd_reg <= proc_mem[choice_reg];
    end

    // Sequencer: scan pass, optional refill pass, result load
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            pipe_vld_reg   <= 1'b0;
            found_reg      <= 1'b0;
            refill_reg     <= 1'b0;
            runnable_reg   <= '0;
            cur_thread_reg <= IDLE_THREAD;
            cur_proc_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            // drop the result once taken, unless a new one loads in its place
            if (m_valid_reg && m_ready && !((state_reg == ST_FINISH) && out_free)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (table_we) begin
                        runnable_reg[set_addr] <= s_data.running;
                    end
                    if (in_fire && (s_data.operation == OP_SCHED)) begin
                        state_reg    <= ST_SCAN;
                        cnt_reg      <= '0;
                        pipe_vld_reg <= 1'b0;
                        found_reg    <= 1'b0;
                        best_q_reg   <= '0;
                        choice_reg   <= '0;
                        refill_reg   <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    // advance the read address
                    if (cnt_reg != CNT_END) begin
                        cnt_reg      <= cnt_reg + 1'b1;
                        pipe_vld_reg <= 1'b1;
                        pipe_idx_reg <= scan_addr;
                    end else begin
                        pipe_vld_reg <= 1'b0;
                    end
                    // keep the first runnable slot with a strictly larger quantum
                    if (pipe_vld_reg && runnable_reg[pipe_idx_reg] &&
                        (!found_reg || (quant_rd_reg > best_q_reg))) begin
                        found_reg  <= 1'b1;
                        best_q_reg <= quant_rd_reg;
                        choice_reg <= pipe_idx_reg;
                    end
                    if (pass_done) begin
                        if (found_reg && (best_q_reg == '0)) begin
                            state_reg  <= ST_REFILL;
                            cnt_reg    <= '0;
                            refill_reg <= 1'b1;
                        end else begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_REFILL: begin
                    if (cnt_reg != CNT_END) begin
                        cnt_reg      <= cnt_reg + 1'b1;
                        pipe_vld_reg <= 1'b1;
                        pipe_idx_reg <= scan_addr;
                    end else begin
                        pipe_vld_reg <= 1'b0;
                    end
                    if (pass_done) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    // hold until the output register is free
                    if (out_free) begin
                        m_valid_reg                <= 1'b1;
                        m_data_reg.chosen_slot     <= found_reg ?
                            choice_ext[SLOT_FIELD_W-1:0] : '0;
                        m_data_reg.chose_idle      <= !found_reg;
                        m_data_reg.context_switch  <= (choice_full != cur_thread_reg);
                        m_data_reg.address_switch  <= (choice_proc != '0) &&
                                                      (choice_proc != cur_proc_reg);
                        m_data_reg.recalculated    <= refill_reg;
                        cur_thread_reg             <= choice_full;
                        cur_proc_reg               <= choice_proc;
                        state_reg                  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // An idle choice carries slot zero and never a refill or address switch
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.chose_idle) |->
            ((m_data.chosen_slot == '0) && !m_data.address_switch &&
             !m_data.recalculated))
        else $error("idle choice with inconsistent result fields");

    // A schedule word blocks the input side in the following cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.operation == OP_SCHED)) |=> !s_ready)
        else $error("input ready right after a schedule word");

    // A new result appears only out of the finish step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result loaded outside the finish step");

endmodule

// File: tb/tb_quantum_thread_scheduler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quantum_thread_scheduler: self-checking bench for the thread scheduler
// Walks a short table of directed words, some with hand-written results,
// then streams random set, yield and schedule sequences. Each word runs
// through a shadow copy of the slot table; each schedule result is checked
// field by field against it or its hand-written result. Both sides idle at
// random, with a long receiver hold-off and a full drain pause along the way.
// ----------------------------------------------------------------------------
module tb_quantum_thread_scheduler;
    import qts_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int TOTAL_WORDS    = 420;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int IDLE_PCT       = 16;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [4:0] IDLE_THREAD = 5'(THREAD_SLOTS_DEF);
    localparam int QUANT_MAX = (1 << QUANTUM_BITS_DEF) - 1;

    typedef struct {
        qts_in_t  word;
        bit       typed;
        qts_out_t want;
    } step_row_t;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    qts_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    qts_out_t m_data;

    // Shadow copy of the slot table and of the running thread
    logic [PRIO_W-1:0]        shadow_prio  [THREAD_SLOTS_DEF];
    logic [QUANT_FIELD_W-1:0] shadow_quant [THREAD_SLOTS_DEF];
    logic                     shadow_run   [THREAD_SLOTS_DEF];
    logic [PROC_W-1:0]        shadow_proc  [THREAD_SLOTS_DEF];
    logic [4:0]               shadow_thread;
    logic [PROC_W-1:0]        shadow_cur_proc;

    qts_out_t  pending_choices[$];
    step_row_t directed_steps[$];

    int  mismatches;
    int  words_in;
    int  results_seen;
    int  refills_seen;
    int  idle_picks;
    int  stall_cycles;
    bit  calm;
    bit  hold_req;

    quantum_thread_scheduler dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #CLK_HALF aclk = ~aclk;

    // Apply one word to the shadow table; return 1 with the choice for schedule
    function automatic bit predict_word(input qts_in_t w, output qts_out_t res);
        bit found;
        logic [4:0] best_slot;
        logic [QUANT_FIELD_W-1:0] best_q;
        logic [PROC_W-1:0] proc;
        int unsigned sum;
        res = '0;
        case (w.operation)
            OP_SET: begin
                if (int'(w.slot) < THREAD_SLOTS_DEF) begin
                    shadow_prio[w.slot]  = w.priority_req;
                    shadow_run[w.slot]   = w.running;
                    shadow_quant[w.slot] = w.quantum;
                    shadow_proc[w.slot]  = w.process_id;
                end
                return 1'b0;
            end
            OP_YIELD: begin
                // the idle thread has no quantum to give up
                if (shadow_thread < IDLE_THREAD)
                    shadow_quant[shadow_thread[3:0]] = '0;
                return 1'b0;
            end
            OP_SCHED: begin
                found = 1'b0;
                best_q = '0;
                best_slot = IDLE_THREAD;
                // strict greater-than keeps the lowest slot on a tie
                for (int i = 0; i < THREAD_SLOTS_DEF; i++) begin
                    if (shadow_run[i] && (!found || shadow_quant[i] > best_q)) begin
                        found = 1'b1;
                        best_q = shadow_quant[i];
                        best_slot = 5'(i);
                    end
                end
                // new epoch: refill every slot, runnable or not
                if (found && best_q == 0) begin
                    for (int i = 0; i < THREAD_SLOTS_DEF; i++) begin
                        sum = shadow_prio[i] + (shadow_quant[i] >> 2);
                        shadow_quant[i] = (sum > QUANT_MAX) ? QUANT_FIELD_W'(QUANT_MAX)
                                                            : QUANT_FIELD_W'(sum);
                    end
                    res.recalculated = 1'b1;
                end
                proc = found ? shadow_proc[best_slot[3:0]] : '0;
                res.chosen_slot    = found ? best_slot[3:0] : '0;
                res.chose_idle     = !found;
                res.context_switch = (best_slot != shadow_thread);
                res.address_switch = (proc != 0) && (proc != shadow_cur_proc);
                shadow_thread   = best_slot;
                shadow_cur_proc = proc;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic qts_in_t mk_word(input logic [OP_W-1:0] op, input int slot,
                                        input int prio, input int run, input int q,
                                        input int pid);
        qts_in_t w;
        w.operation    = op;
        w.slot         = SLOT_FIELD_W'(slot);
        w.priority_req = PRIO_W'(prio);
        w.running      = run[0];
        w.quantum      = QUANT_FIELD_W'(q);
        w.process_id   = PROC_W'(pid);
        return w;
    endfunction

    function automatic qts_out_t outcome(input int slot, input bit idle, input bit cs,
                                         input bit as, input bit rc);
        qts_out_t r;
        r.chosen_slot    = SLOT_FIELD_W'(slot);
        r.chose_idle     = idle;
        r.context_switch = cs;
        r.address_switch = as;
        r.recalculated   = rc;
        return r;
    endfunction

    // Kernel, a few shared processes, or anything
    function automatic int rand_pid();
        case ($urandom_range(3))
            0:       return 0;
            1:       return $urandom_range(3, 1);
            default: return $urandom_range(255);
        endcase
    endfunction

    function automatic qts_in_t rand_set(input bit zero_quantum);
        int q;
        q = (zero_quantum || $urandom_range(3) == 0) ? 0 : $urandom_range(255);
        return mk_word(OP_SET, $urandom_range(15), $urandom_range(63),
                       zero_quantum || ($urandom_range(99) < 80), q, rand_pid());
    endfunction

    task automatic add_row(input qts_in_t w, input bit typed, input qts_out_t want);
        step_row_t row;
        row.word  = w;
        row.typed = typed;
        row.want  = want;
        directed_steps.push_back(row);
    endtask

    // Offer one word, hold it until taken, then advance the shadow table
    task automatic send_word(input qts_in_t w, input bit typed, input qts_out_t want);
        qts_out_t guess;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (w.operation != OP_UNUSED) words_in++;
        if (predict_word(w, guess))
            pending_choices.push_back(typed ? want : guess);
    endtask

    task automatic send_plain(input qts_in_t w);
        send_word(w, 1'b0, '0);
    endtask

    // Drop valid and wait for every outstanding schedule result
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_choices.size() != 0) @(posedge aclk);
    endtask

    // Stimulus
    initial begin
        int n;
        bit hold_done;
        bit drain_done;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;
        mismatches = 0;
        words_in = 0;
        results_seen = 0;
        refills_seen = 0;
        idle_picks = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        drain_done = 1'b0;
        for (int i = 0; i < THREAD_SLOTS_DEF; i++) begin
            shadow_prio[i]  = '0;
            shadow_quant[i] = '0;
            shadow_run[i]   = 1'b0;
            shadow_proc[i]  = '0;
        end
        shadow_thread   = IDLE_THREAD;
        shadow_cur_proc = '0;

        // Directed table: hand-written results where they are obvious
        add_row(mk_word(OP_SCHED, 0, 0, 0, 0, 0), 1'b1, outcome(0, 1, 0, 0, 0));
        add_row(mk_word(OP_YIELD, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_word(OP_UNUSED, 15, 63, 1, 255, 255), 1'b0, '0);
        add_row(mk_word(OP_SET, 15, 63, 1, 255, 255), 1'b0, '0);
        add_row(mk_word(OP_SET, 0, 0, 1, 0, 0), 1'b0, '0);
        add_row(mk_word(OP_SCHED, 0, 0, 0, 0, 0), 1'b1, outcome(15, 0, 1, 1, 0));
        add_row(mk_word(OP_SCHED, 0, 0, 0, 0, 0), 1'b1, outcome(15, 0, 0, 0, 0));
        add_row(mk_word(OP_YIELD, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_word(OP_SCHED, 0, 0, 0, 0, 0), 1'b1, outcome(0, 0, 1, 0, 1));
        add_row(mk_word(OP_SCHED, 0, 0, 0, 0, 0), 1'b1, outcome(15, 0, 1, 1, 0));
        add_row(mk_word(OP_SET, 15, 63, 0, 0, 255), 1'b0, '0);
        add_row(mk_word(OP_SET, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_word(OP_SCHED, 0, 0, 0, 0, 0), 1'b1, outcome(0, 1, 1, 0, 0));
        add_row(mk_word(OP_SET, 5, 63, 0, 255, 1), 1'b0, '0);
        add_row(mk_word(OP_SET, 3, 10, 1, 0, 7), 1'b0, '0);
        add_row(mk_word(OP_SET, 9, 42, 1, 0, 7), 1'b0, '0);
        add_row(mk_word(OP_SCHED, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_word(OP_SCHED, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_word(OP_YIELD, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_word(OP_SCHED, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_word(OP_SET, 9, 1, 1, 255, 0), 1'b0, '0);
        add_row(mk_word(OP_SCHED, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_word(OP_SCHED, 15, 63, 1, 255, 255), 1'b0, '0);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_steps[i])
            send_word(directed_steps[i].word, directed_steps[i].typed,
                      directed_steps[i].want);

        // Random sequences until the word budget is spent
        while (words_in < TOTAL_WORDS) begin
            calm = (words_in >= 170 && words_in < 250);

            // hold the receiver off while schedules pile up behind it
            if (!hold_done && words_in >= 100) begin
                hold_done = 1'b1;
                hold_req = 1'b1;
                repeat (3) send_plain(rand_set(1'b0));
                repeat (10) send_plain(mk_word(OP_SCHED, 0, 0, 0, 0, 0));
            end

            if (!drain_done && words_in >= 300) begin
                drain_done = 1'b1;
                drain_results();
            end

            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    n = $urandom_range(4, 1);
                    repeat (n) send_plain(rand_set(1'b0));
                    send_plain(mk_word(OP_SCHED, $urandom_range(15), $urandom_range(63),
                                       $urandom_range(1), $urandom_range(255),
                                       $urandom_range(255)));
                end
                4, 5, 6: begin
                    // drain quanta one thread at a time toward a new epoch
                    n = $urandom_range(5, 1);
                    repeat (n) begin
                        send_plain(mk_word(OP_YIELD, $urandom_range(15), 0, 0, 0, 0));
                        send_plain(mk_word(OP_SCHED, 0, 0, 0, 0, 0));
                    end
                end
                7: begin
                    n = $urandom_range(3, 1);
                    repeat (n) send_plain(mk_word(OP_SCHED, 0, 0, 0, 0, 0));
                end
                8: begin
                    send_plain($bits(qts_in_t)'($urandom));
                end
                default: begin
                    n = $urandom_range(3, 1);
                    repeat (n) send_plain(rand_set(1'b1));
                    send_plain(mk_word(OP_SCHED, 0, 0, 0, 0, 0));
                end
            endcase
        end
        calm = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d words, %0d schedule results checked", words_in,
                 results_seen);
        $display("  %0d epoch refills, %0d idle picks, one long output hold-off",
                 refills_seen, idle_picks);
        if (mismatches == 0) begin
            $display("quantum_thread_scheduler: match");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("quantum_thread_scheduler: mismatch");
        end
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off on request
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                stall_cycles = 0;
                while (stall_cycles < HOLD_CYCLES) begin
                    @(posedge aclk);
                    stall_cycles++;
                end
                hold_req = 1'b0;
            end
            m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Check each taken result against the oldest expected choice
    always @(posedge aclk) begin
        qts_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_data.recalculated) refills_seen++;
            if (m_data.chose_idle) idle_picks++;
            if (pending_choices.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with nothing pending: slot %0d idle %0b",
                             $realtime, m_data.chosen_slot, m_data.chose_idle);
            end else begin
                want = pending_choices.pop_front();
                if (m_data.chosen_slot !== want.chosen_slot
                        || m_data.chose_idle !== want.chose_idle
                        || m_data.context_switch !== want.context_switch
                        || m_data.address_switch !== want.address_switch
                        || m_data.recalculated !== want.recalculated) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: slot/idle/cs/as/rc expected %0d %0b %0b %0b %0b",
                                 $realtime, want.chosen_slot, want.chose_idle,
                                 want.context_switch, want.address_switch,
                                 want.recalculated);
                        $display("               got %0d %0b %0b %0b %0b",
                                 m_data.chosen_slot, m_data.chose_idle,
                                 m_data.context_switch, m_data.address_switch,
                                 m_data.recalculated);
                    end
                end
            end
        end
    end

    // End the run if no word moves on either side for too long
    always @(posedge aclk) begin
        int quiet;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("timeout with %0d results pending", pending_choices.size());
                $display("quantum_thread_scheduler: mismatch");
                $finish;
            end
        end
    end

endmodule

// File: files.f
hdl/qts_pkg.sv
hdl/quantum_thread_scheduler.sv
tb/tb_quantum_thread_scheduler.sv
